>>> rtl/spe_pkg.sv
// Shared constants for the sparse polynomial evaluator.
// Field widths, command codes and the default table depth.
// No dependencies.
`timescale 1ns / 1ps

package spe_pkg;

  // Field widths
  localparam int DATA_W  = 32;  // coefficient, x and result
  localparam int EXP_W   = 5;   // exponent
  localparam int CNT_W   = 5;   // term count register
  localparam int INDEX_W = 4;   // term_index port

  // Default table depth
  localparam int DEF_MAX_TERMS = 16;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

endpackage

>>> rtl/sparse_polynomial_evaluator.sv
// Sparse polynomial evaluator: sum of coef * x^exp over a term table in one RAM.
// Load: writes one table entry, no result. Evaluate: powers x^2..x^16 are built
// by repeated squaring, then the term pipeline reads one RAM entry per cycle
// (3 multiply stages) and the accumulated sum is registered as the result.
// Next item is taken the cycle after the result is registered. Sync reset clears
// control and term_count; the term RAM is not cleared and must be loaded before use.
`timescale 1ns / 1ps

module sparse_polynomial_evaluator
  import spe_pkg::*;
#(
  parameter int MAX_TERMS = DEF_MAX_TERMS
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_data,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [INDEX_W-1:0]  term_index,
  input  logic signed [DATA_W-1:0] term_coef,
  input  logic [EXP_W-1:0]    term_exp,
  input  logic signed [DATA_W-1:0] x_value,
  // output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [DATA_W-1:0] poly_value
);

  localparam int IDX_W   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int ENTRY_W = DATA_W + EXP_W;
  localparam logic [8:0] MAX_T9 = 9'(MAX_TERMS);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  term_count;
  logic [CNT_W-1:0]  n_terms;
  logic [CNT_W-1:0]  issue_cnt;
  logic [1:0]        sq_cnt;

  // Term RAM: {coef, exp} per entry
  logic [ENTRY_W-1:0] mem [MAX_TERMS];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W+INDEX_W-1:0] wr_ext;
  logic [IDX_W+CNT_W-1:0]   rd_ext;
  logic               idx_ok;

  // Powers of x
  logic [DATA_W-1:0] pw1, pw2, pw4, pw8, pw16;
  logic [DATA_W-1:0] sq_in, sq_prod;

  // Term pipeline
  logic              rd_v, s1_v, s2_v, s3_v;
  logic [DATA_W-1:0] s1_a, s1_b, s1_d;
  logic [DATA_W-1:0] s2_c, s2_d;
  logic [DATA_W-1:0] s3_p;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] rd_coef;
  logic [EXP_W-1:0]  rd_exp;
  logic [DATA_W-1:0] f0, f1, f2, f3, f4;

  logic in_xfer, issue, pipe_empty, out_free;
  logic [8:0] cfg9, idx9;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Config write, saturated to the table depth
  assign cfg9 = {4'b0, cfg_data};
  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= '0;
    end else if (cfg_we) begin
      if (cfg9 > MAX_T9) begin
        term_count <= MAX_T9[CNT_W-1:0];
      end else begin
        term_count <= cfg_data;
      end
    end
  end

  // RAM addressing
  assign idx9    = {5'b0, term_index};
  assign idx_ok  = (idx9 < MAX_T9);
  assign wr_ext  = {{IDX_W{1'b0}}, term_index};
  assign wr_addr = wr_ext[IDX_W-1:0];
  assign rd_ext  = {{IDX_W{1'b0}}, issue_cnt};
  assign rd_addr = rd_ext[IDX_W-1:0];
  assign issue   = (state == ST_RUN) && (issue_cnt < n_terms);

  always_ff @(posedge clk) begin
    if (in_xfer && cmd == CMD_LOAD && idx_ok) begin
      mem[wr_addr] <= {term_coef, term_exp};
    end
    if (issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Squaring unit for x^2 .. x^16
  always_comb begin
    case (sq_cnt)
      2'd0:    sq_in = pw1;
      2'd1:    sq_in = pw2;
      2'd2:    sq_in = pw4;
      2'd3:    sq_in = pw8;
      default: sq_in = pw1;
    endcase
  end
  assign sq_prod = sq_in * sq_in;

  always_ff @(posedge clk) begin
    if (in_xfer && cmd == CMD_EVAL) begin
      pw1 <= x_value;
    end
    if (state == ST_PREP) begin
      case (sq_cnt)
        2'd0:    pw2  <= sq_prod;
        2'd1:    pw4  <= sq_prod;
        2'd2:    pw8  <= sq_prod;
        2'd3:    pw16 <= sq_prod;
        default: pw2  <= sq_prod;
      endcase
    end
  end

  // Stage 1: pick power factors from exponent bits, start the products
  assign rd_coef = rd_data[ENTRY_W-1:EXP_W];
  assign rd_exp  = rd_data[EXP_W-1:0];
  assign f0 = rd_exp[0] ? pw1  : DATA_W'(1);
  assign f1 = rd_exp[1] ? pw2  : DATA_W'(1);
  assign f2 = rd_exp[2] ? pw4  : DATA_W'(1);
  assign f3 = rd_exp[3] ? pw8  : DATA_W'(1);
  assign f4 = rd_exp[4] ? pw16 : DATA_W'(1);

  // Datapath registers, all products wrap to 32 bits
  always_ff @(posedge clk) begin
    s1_a <= f0 * f1;
    s1_b <= f2 * f3;
    s1_d <= rd_coef * f4;
    s2_c <= s1_a * s1_b;
    s2_d <= s1_d;
    s3_p <= s2_c * s2_d;
  end

  // Pipeline valids and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      rd_v <= issue;
      s1_v <= rd_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && cmd == CMD_EVAL) begin
      sum <= '0;
    end else if (s3_v) begin
      sum <= sum + s3_p;
    end
  end

  assign pipe_empty = !rd_v && !s1_v && !s2_v && !s3_v;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer && cmd == CMD_EVAL) state_next = ST_PREP;
      end
      ST_PREP: begin
        if (sq_cnt == 2'd3) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (!issue && pipe_empty) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sq_cnt    <= '0;
      issue_cnt <= '0;
      n_terms   <= '0;
    end else begin
      state <= state_next;
      if (in_xfer && cmd == CMD_EVAL) begin
        sq_cnt    <= '0;
        issue_cnt <= '0;
        n_terms   <= term_count;
      end else begin
        if (state == ST_PREP) sq_cnt <= sq_cnt + 2'd1;
        if (issue) issue_cnt <= issue_cnt + CNT_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      poly_value <= sum;
    end
  end

endmodule

>>> rtl/spe_checker.sv
// Port-level checks for the sparse polynomial evaluator.
// Depends on spe_pkg; bound to the top level below.
`timescale 1ns / 1ps

module spe_checker
  import spe_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                cmd,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [DATA_W-1:0] poly_value
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(poly_value))
    else $error("stalled result changed");

  // An evaluate transfer makes the block busy
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_EVAL |=> !in_ready)
    else $error("ready after evaluate transfer");

  // A load transfer leaves the block ready in the cycle after it
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_LOAD |=> in_ready)
    else $error("not ready after load transfer");

  // Reset empties the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sparse_polynomial_evaluator spe_checker u_spe_checker (.*);
